### sv/bbspmv_pkg.sv
// shared types, codes and helpers for the bitmap-blocked spmv accumulator
// no dependencies
`default_nettype none

package bbspmv_pkg;

  localparam int BlockDim  = 4;
  localparam int CellCount = BlockDim * BlockDim;
  localparam int CellW     = $clog2(CellCount);
  localparam int DimW      = $clog2(BlockDim);
  localparam int QDepth    = 4;
  localparam int QPtrW     = $clog2(QDepth);

  // input action codes
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_VALUE = 2'd1;
  localparam logic [1:0] ACT_FLUSH = 2'd2;

  // sticky error flags
  localparam logic [1:0] FLAG_SURPLUS = 2'b01;
  localparam logic [1:0] FLAG_EARLY   = 2'b10;

  typedef enum logic [1:0] {
    OP_MAC,
    OP_FLUSH,
    OP_ERR
  } op_kind_e;

  // work handed from front to back
  typedef struct packed {
    op_kind_e           kind;
    logic [DimW-1:0]    row;
    logic [1:0]         err;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } op_t;

  // index of the lowest set bit, zero when none is set
  function automatic logic [CellW-1:0] lowest_set(input logic [CellCount-1:0] bits);
    logic [CellW-1:0] idx;
    idx = '0;
    for (int i = CellCount - 1; i >= 0; i--) begin
      if (bits[i]) idx = CellW'(i);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

### sv/bitmap_block_spmv_accumulator.sv
// top level of the bitmap-blocked 4x4 sparse matrix-vector accumulator
// ties front end, op queue and back end together; uses bbspmv_pkg
//
// Usage:
//   Input words enter through a queue-like port: a word is taken at a clock
//   edge with push high and full low. A start word loads the block bitmap
//   and four x entries, a value word multiplies the next nonzero into its
//   row sum, a flush word returns the four row sums and the error status.
//   Results leave through a queue-like port: while empty is low the oldest
//   result is on sum0..sum3/status, and pop with empty low takes it.
//   Throughput is one word per cycle while full is low; the front end
//   picks the cell in the cycle a word arrives, and the back end does one
//   multiply-accumulate per cycle unless stalled, through a registered
//   multiply stage and the accumulator stage. A flush result is
//   registered and waits behind any older words in the four-entry op
//   queue. When the receiver stalls, one result is held; the back end
//   stops at the next flush and the op queue fills, then full is raised.
//   Reset clears the bitmap, x entries, row sums, error flags and queues.
`default_nettype none

module bitmap_block_spmv_accumulator (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [1:0]         action_i,
  input  wire logic [15:0]        occupancy_i,
  input  wire logic signed [31:0] xin0_i,
  input  wire logic signed [31:0] xin1_i,
  input  wire logic signed [31:0] xin2_i,
  input  wire logic signed [31:0] xin3_i,
  input  wire logic signed [31:0] entry_i,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [63:0]      sum0_o,
  output logic signed [63:0]      sum1_o,
  output logic signed [63:0]      sum2_o,
  output logic signed [63:0]      sum3_o,
  output logic [1:0]              status_o
);

  logic            accept;
  logic            f_valid;
  bbspmv_pkg::op_t f_op;
  logic            q_valid;
  bbspmv_pkg::op_t q_op;
  logic            q_take;
  logic            out_valid;

  assign accept = push && !full;
  assign empty  = !out_valid;

  // classify incoming words
  bbspmv_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .action_i    (action_i),
    .occupancy_i (occupancy_i),
    .xin0_i      (xin0_i),
    .xin1_i      (xin1_i),
    .xin2_i      (xin2_i),
    .xin3_i      (xin3_i),
    .entry_i     (entry_i),
    .op_valid_o  (f_valid),
    .op_o        (f_op)
  );

  // decouple front and back
  bbspmv_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (accept && f_valid),
    .wr_op_i (f_op),
    .full_o  (full),
    .rd_i    (q_take),
    .valid_o (q_valid),
    .rd_op_o (q_op)
  );

  // multiply, accumulate, emit
  bbspmv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (q_valid),
    .op_i        (q_op),
    .op_take_o   (q_take),
    .pop_i       (pop),
    .out_valid_o (out_valid),
    .sum0_o      (sum0_o),
    .sum1_o      (sum1_o),
    .sum2_o      (sum2_o),
    .sum3_o      (sum3_o),
    .status_o    (status_o)
  );

endmodule

`default_nettype wire

### sv/bbspmv_front.sv
// front end: holds the block bitmap and x entries, picks the next cell,
// classifies each incoming word into a back-end op; uses bbspmv_pkg
`default_nettype none

module bbspmv_front (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    accept_i,
  input  wire logic [1:0]              action_i,
  input  wire logic [15:0]             occupancy_i,
  input  wire logic signed [31:0]      xin0_i,
  input  wire logic signed [31:0]      xin1_i,
  input  wire logic signed [31:0]      xin2_i,
  input  wire logic signed [31:0]      xin3_i,
  input  wire logic signed [31:0]      entry_i,
  output logic                         op_valid_o,
  output bbspmv_pkg::op_t              op_o
);

  logic [bbspmv_pkg::CellCount-1:0] pending_q, pending_d;
  logic signed [31:0]               xseg_q [bbspmv_pkg::BlockDim];
  logic [bbspmv_pkg::CellW-1:0]     pick;

  assign pick = bbspmv_pkg::lowest_set(pending_q);

  // classify the word and build the op
  always_comb begin
    pending_d  = pending_q;
    op_valid_o = 1'b0;
    op_o.kind  = bbspmv_pkg::OP_ERR;
    op_o.row   = pick[bbspmv_pkg::CellW-1:bbspmv_pkg::DimW];
    op_o.err   = '0;
    op_o.a     = entry_i;
    op_o.b     = xseg_q[pick[bbspmv_pkg::DimW-1:0]];
    case (action_i)
      bbspmv_pkg::ACT_START: begin
        pending_d = occupancy_i;
        if (pending_q != '0) begin
          op_valid_o = 1'b1;
          op_o.err   = bbspmv_pkg::FLAG_EARLY;
        end
      end
      bbspmv_pkg::ACT_VALUE: begin
        op_valid_o = 1'b1;
        if (pending_q == '0) begin
          op_o.err = bbspmv_pkg::FLAG_SURPLUS;
        end else begin
          op_o.kind = bbspmv_pkg::OP_MAC;
          pending_d = pending_q & (pending_q - 1'b1);
        end
      end
      bbspmv_pkg::ACT_FLUSH: begin
        op_valid_o = 1'b1;
        op_o.kind  = bbspmv_pkg::OP_FLUSH;
      end
      default: ;
    endcase
  end

  // bitmap and x entry registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
      for (int i = 0; i < bbspmv_pkg::BlockDim; i++) xseg_q[i] <= '0;
    end else if (accept_i) begin
      pending_q <= pending_d;
      if (action_i == bbspmv_pkg::ACT_START) begin
        xseg_q[0] <= xin0_i;
        xseg_q[1] <= xin1_i;
        xseg_q[2] <= xin2_i;
        xseg_q[3] <= xin3_i;
      end
    end
  end

endmodule

`default_nettype wire

### sv/bbspmv_queue.sv
// short op queue between front and back end
// uses bbspmv_pkg for the op type and depth
`default_nettype none

module bbspmv_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            wr_i,
  input  wire bbspmv_pkg::op_t wr_op_i,
  output logic                 full_o,
  input  wire logic            rd_i,
  output logic                 valid_o,
  output bbspmv_pkg::op_t      rd_op_o
);

  bbspmv_pkg::op_t                entries_q [bbspmv_pkg::QDepth];
  logic [bbspmv_pkg::QPtrW-1:0]   wptr_q, rptr_q;
  logic [bbspmv_pkg::QPtrW:0]     count_q;
  logic                           do_wr, do_rd;

  assign full_o  = (count_q == (bbspmv_pkg::QPtrW+1)'(bbspmv_pkg::QDepth));
  assign valid_o = (count_q != '0);
  assign rd_op_o = entries_q[rptr_q];
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && valid_o;

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_wr) entries_q[wptr_q] <= wr_op_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_wr) wptr_q <= wptr_q + 1'b1;
      if (do_rd) rptr_q <= rptr_q + 1'b1;
      if (do_wr && !do_rd)      count_q <= count_q + 1'b1;
      else if (do_rd && !do_wr) count_q <= count_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

### sv/bbspmv_back.sv
// back end: multiply stage, saturating row accumulators, result register
// uses bbspmv_pkg for op type and codes
`default_nettype none

module bbspmv_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 op_valid_i,
  input  wire bbspmv_pkg::op_t      op_i,
  output logic                      op_take_o,
  input  wire logic                 pop_i,
  output logic                      out_valid_o,
  output logic signed [63:0]        sum0_o,
  output logic signed [63:0]        sum1_o,
  output logic signed [63:0]        sum2_o,
  output logic signed [63:0]        sum3_o,
  output logic [1:0]                status_o
);

  logic                           s1_v_q;
  bbspmv_pkg::op_kind_e           s1_kind_q;
  logic [bbspmv_pkg::DimW-1:0]    s1_row_q;
  logic [1:0]                     s1_err_q;
  logic signed [63:0]             s1_prod_q, prod_d;

  logic signed [63:0]             acc_q [bbspmv_pkg::BlockDim];
  logic [1:0]                     err_q;
  logic signed [63:0]             out_q [bbspmv_pkg::BlockDim];
  logic [1:0]                     out_status_q;
  logic                           out_v_q;

  logic                           out_free, retire, s1_load;
  logic signed [63:0]             acc_sel, acc_sum, acc_new;

  assign out_free  = !out_v_q || pop_i;
  assign retire    = s1_v_q && ((s1_kind_q != bbspmv_pkg::OP_FLUSH) || out_free);
  assign s1_load   = !s1_v_q || retire;
  assign op_take_o = op_valid_i && s1_load;

  // multiply stage
  assign prod_d = op_i.a * op_i.b;

  always_ff @(posedge clk_i) begin
    if (op_take_o) begin
      s1_kind_q <= op_i.kind;
      s1_row_q  <= op_i.row;
      s1_err_q  <= op_i.err;
      s1_prod_q <= prod_d;
    end
  end

  // saturating add into the selected row
  always_comb begin
    acc_sel = acc_q[s1_row_q];
    acc_sum = acc_sel + s1_prod_q;
    acc_new = acc_sum;
    if ((acc_sel[63] == s1_prod_q[63]) && (acc_sum[63] != acc_sel[63])) begin
      acc_new = acc_sel[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
  end

  // retire: accumulate, flag errors or flush into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      err_q   <= '0;
      out_v_q <= 1'b0;
      for (int i = 0; i < bbspmv_pkg::BlockDim; i++) acc_q[i] <= '0;
    end else begin
      if (s1_load) s1_v_q <= op_valid_i;
      // result valid: a new flush word wins over the pop of the old one
      if (retire && (s1_kind_q == bbspmv_pkg::OP_FLUSH)) begin
        out_v_q <= 1'b1;
      end else if (pop_i) begin
        out_v_q <= 1'b0;
      end
      if (retire) begin
        case (s1_kind_q)
          bbspmv_pkg::OP_MAC:   acc_q[s1_row_q] <= acc_new;
          bbspmv_pkg::OP_ERR:   err_q <= err_q | s1_err_q;
          bbspmv_pkg::OP_FLUSH: begin
            err_q   <= '0;
            for (int i = 0; i < bbspmv_pkg::BlockDim; i++) acc_q[i] <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (retire && (s1_kind_q == bbspmv_pkg::OP_FLUSH)) begin
      for (int i = 0; i < bbspmv_pkg::BlockDim; i++) out_q[i] <= acc_q[i];
      out_status_q <= err_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign sum0_o      = out_q[0];
  assign sum1_o      = out_q[1];
  assign sum2_o      = out_q[2];
  assign sum3_o      = out_q[3];
  assign status_o    = out_status_q;

endmodule

`default_nettype wire
